[rtl/rvm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_pkg
// Shared opcodes, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package rvm_pkg;

  localparam int MemBytesDefault = 65536;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FAULT = 3'd1;
  localparam logic [2:0] ST_BADFN = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_CALL  = 3'd4;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SETPC = 2'd1;
  localparam logic [1:0] OP_EXEC = 2'd2;

  localparam logic [7:0] I_NOP = 8'd0, I_LOAD = 8'd1, I_EXT = 8'd2, I_W8 = 8'd3,
    I_R8 = 8'd4, I_W16 = 8'd5, I_R16 = 8'd6, I_W32 = 8'd7, I_R32 = 8'd8,
    I_SWAP = 8'd9, I_MOVE = 8'd10, I_MOVEIF = 8'd11, I_MOVEIFZ = 8'd12,
    I_STOP = 8'd13, I_LSH = 8'd14, I_RSH = 8'd15, I_SSH = 8'd16, I_AND = 8'd17,
    I_OR = 8'd18, I_XOR = 8'd19, I_NEG = 8'd20, I_INCR = 8'd21, I_DECR = 8'd22,
    I_INCR4 = 8'd23, I_DECR4 = 8'd24, I_ADD = 8'd25, I_SUB = 8'd26,
    I_MUL = 8'd27, I_DIV = 8'd28, I_OUT = 8'd29, I_IN = 8'd30;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       mem_rd;     // read byte at mem_addr, data next cycle
    logic       mem_wr;     // write wr_byte at mem_addr
    logic [1:0] addr_sel;   // 0 load_addr, 1 pc+k, 2 base+k
    logic [1:0] k;          // byte offset
    logic [1:0] wr_sel;     // 0 load_byte, 1 byte k of wdata word
    logic [1:0] cap;        // capture read byte: 0 none,1 opcode,2 A,3 B
    logic       cap_c;      // capture C index
    logic       cap_word;   // shift read byte into word register
    logic       clr_word;
    logic       cap_in;     // latch the console character of an accepted beat
    logic       rd_ops;     // latch register operands
    logic       set_pc;
    logic       pc_adv;     // pc += 4
    logic       div_start;
    logic       write_a;    // write alu result into R[A]
    logic       write_b_swap;
    logic       write_rem;
    logic       set_base;   // base <- address for memory ops
  } rvm_cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       fetch_ok;
    logic       addr_ok;    // access at base with the current opcode's size
    logic       ext_ok;
    logic       vc_zero;
    logic       div_done;
  } rvm_sts_t;

endpackage
`default_nettype wire

[rtl/rvm_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvm_div import rvm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;

  assign trial = {rem, quot[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd32;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
    end else if (run) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quot[31]};
        quot <= {quot[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/rvm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_datapath
// Register file, byte memory, ALU, and the multiply and divide units.
// ----------------------------------------------------------------------------
module rvm_datapath import rvm_pkg::*; #(
  parameter int MEM_BYTES = MemBytesDefault,
  localparam int AW = $clog2(MEM_BYTES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rvm_cmd_t           cmd,
  output rvm_sts_t                sts,
  input  wire logic [15:0]        load_addr,
  input  wire logic [7:0]         load_byte,
  input  wire logic [31:0]        new_pc,
  input  wire logic signed [8:0]  in_char,
  input  wire logic [7:0]         function_count,
  output logic [31:0]             pc,
  output logic [7:0]              out_char_val,
  output logic [31:0]             call_val
);
  localparam logic [32:0] MemSize = 33'(MEM_BYTES);

  logic [31:0] regs [32];
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rd_byte;
  logic [7:0]  opcode;
  logic [4:0]  ia, ib, ic;
  logic [31:0] va, vb, vc, base, word, prod, res;
  logic [31:0] addr_full;
  logic [AW-1:0] maddr;
  logic [7:0]  wbyte;
  logic [31:0] wsrc;
  logic [32:0] lim;
  logic        dv_done;
  logic [31:0] dv_q, dv_r;
  logic [4:0]  sh;
  logic signed [8:0] in_ch;

  assign pc = regs[0];

  always_comb begin
    unique case (cmd.addr_sel)
      2'd0:    addr_full = 32'(load_addr);
      2'd1:    addr_full = regs[0] + 32'(cmd.k);
      default: addr_full = base + 32'(cmd.k);
    endcase
  end
  assign maddr = addr_full[AW-1:0];

  // Source word for stores: W8/W16 take B, W32 takes A.
  assign wsrc = (opcode == I_W32) ? va : vb;
  always_comb begin
    if (cmd.wr_sel == 2'd0) begin
      wbyte = load_byte;
    end else if (opcode == I_W32) begin
      wbyte = wsrc[8*(3-cmd.k) +: 8];
    end else begin
      wbyte = (cmd.k == 2'd0 && opcode == I_W16) ? wsrc[15:8] : wsrc[7:0];
    end
  end

  // A load beat beyond the end of memory is dropped.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && {1'b0, addr_full} < MemSize) mem[maddr] <= wbyte;
    if (cmd.mem_rd) rd_byte <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap == 2'd1) opcode <= rd_byte;
    if (cmd.cap == 2'd2) ia <= rd_byte[4:0];
    if (cmd.cap == 2'd3) ib <= rd_byte[4:0];
    if (cmd.cap_c) ic <= rd_byte[4:0];
    if (cmd.cap_in) in_ch <= in_char;
    if (cmd.clr_word) word <= '0;
    else if (cmd.cap_word) word <= {word[23:0], rd_byte};
    if (cmd.rd_ops) begin
      va <= regs[ia];
      vb <= regs[ib];
      vc <= regs[ic];
    end
    if (cmd.set_base) base <= (opcode == I_LOAD) ? regs[0] :
        (opcode == I_W8 || opcode == I_W16) ? va : vb;
    prod <= vb * vc;
  end

  // Limits use 33 bits so an address near 2^32 cannot wrap.
  always_comb begin
    unique case (opcode)
      I_W8, I_R8:   lim = {1'b0, base} + 33'd1;
      I_W16, I_R16: lim = {1'b0, base} + 33'd2;
      default:      lim = {1'b0, base} + 33'd4;
    endcase
  end
  assign sts.addr_ok  = lim <= MemSize;
  assign sts.fetch_ok = ({1'b0, regs[0]} + 33'd4) <= MemSize;
  assign sts.opcode   = opcode;
  assign sts.ext_ok   = va < 32'(function_count);
  assign sts.vc_zero  = vc == '0;
  assign sts.div_done = dv_done;
  assign out_char_val = va[7:0];
  assign call_val     = va;
  assign sh           = vc[4:0];

  // Memory reads complete with the last byte still in rd_byte.
  always_comb begin
    unique case (opcode)
      I_LOAD, I_R32: res = {word[23:0], rd_byte};
      I_R8:      res = {24'd0, rd_byte};
      I_R16:     res = {16'd0, word[7:0], rd_byte};
      I_LSH:     res = vb << sh;
      I_RSH:     res = vb >> sh;
      I_SSH:     res = 32'($signed(vb) >>> sh);
      I_AND:     res = vb & vc;
      I_OR:      res = vb | vc;
      I_XOR:     res = vb ^ vc;
      I_NEG:     res = ~vb;
      I_INCR:    res = va + 32'd1;
      I_DECR:    res = va - 32'd1;
      I_INCR4:   res = va + 32'd4;
      I_DECR4:   res = va - 32'd4;
      I_ADD:     res = vb + vc;
      I_SUB:     res = vb - vc;
      I_MUL:     res = prod;
      I_DIV:     res = dv_q;
      I_IN:      res = 32'($signed(in_ch));
      default:   res = vb;
    endcase
  end

  rvm_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(vb), .divisor(vc),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  // Register writes happen in order: pc first, then A, then remainder, so
  // that a destination of 0 or 31 ends as in sequential execution.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else begin
      if (cmd.set_pc) regs[0] <= new_pc;
      if (cmd.pc_adv) regs[0] <= regs[0] + 32'd4;
      if (cmd.write_b_swap) regs[ib] <= va;
      if (cmd.write_a) regs[ia] <= res;
      if (cmd.write_rem) regs[31] <= dv_r;
    end
  end
endmodule
`default_nettype wire

[rtl/rvm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_ctrl
// Sequencer: fetch four bytes, read operands, run the opcode, report.
// ----------------------------------------------------------------------------
module rvm_ctrl import rvm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] op,
  input  wire rvm_sts_t   sts,
  output rvm_cmd_t        cmd,
  output logic            busy,
  output logic            done,
  output logic [2:0]      status,
  output logic            out_valid,
  output logic            call_valid,
  output logic            stopped
);
  localparam logic [3:0] S_IDLE = 4'd0, S_FETCH = 4'd1, S_OPS = 4'd2,
    S_DISP = 4'd3, S_MEM = 4'd4, S_MULW = 4'd5, S_DIVW = 4'd6, S_MEMW = 4'd7;

  logic [3:0] state, state_next;
  logic [2:0] cnt, cnt_next;
  logic [7:0] opc;
  logic [2:0] nbytes;
  logic       is_wr;

  assign opc = sts.opcode;
  assign busy = state != S_IDLE;
  assign is_wr = opc == I_W8 || opc == I_W16 || opc == I_W32;
  always_comb begin
    unique case (opc)
      I_W8, I_R8:   nbytes = 3'd1;
      I_W16, I_R16: nbytes = 3'd2;
      default:      nbytes = 3'd4;
    endcase
  end

  logic       fin;
  logic [2:0] fin_st;
  logic       fin_ov, fin_call, set_stop, clr_stop;

  always_comb begin
    cmd = '0;
    state_next = state;
    cnt_next = cnt;
    fin = 1'b0;
    fin_st = ST_OK;
    fin_ov = 1'b0;
    fin_call = 1'b0;
    set_stop = 1'b0;
    clr_stop = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            cmd.mem_wr = 1'b1;
            fin = 1'b1;
          end else if (op == OP_SETPC) begin
            cmd.set_pc = 1'b1;
            clr_stop = 1'b1;
            fin = 1'b1;
          end else if (op == OP_EXEC) begin
            cmd.cap_in = 1'b1;
            state_next = S_FETCH;
            cnt_next = '0;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_FETCH: begin
        // Byte k is requested at count k and captured in the next cycle.
        if (cnt == 3'd0 && !sts.fetch_ok) begin
          fin = 1'b1;
          fin_st = ST_FAULT;
          state_next = S_IDLE;
        end else begin
          cmd.addr_sel = 2'd1;
          cmd.k = cnt[1:0];
          cmd.mem_rd = cnt < 3'd4;
          cmd.cap = (cnt == 3'd1) ? 2'd1 : (cnt == 3'd2) ? 2'd2 :
              (cnt == 3'd3) ? 2'd3 : 2'd0;
          cmd.cap_c = cnt == 3'd4;
          cnt_next = cnt + 3'd1;
          if (cnt == 3'd4) begin
            cmd.pc_adv = 1'b1;
            state_next = S_OPS;
          end
        end
      end
      S_OPS: begin
        cmd.rd_ops = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        state_next = S_IDLE;
        fin = 1'b1;
        unique case (opc)
          I_NOP: ;
          I_EXT: begin
            if (sts.ext_ok) begin
              fin_st = ST_CALL;
              fin_call = 1'b1;
            end else begin
              fin_st = ST_BADFN;
            end
          end
          I_LOAD, I_W8, I_R8, I_W16, I_R16, I_W32, I_R32: begin
            cmd.set_base = 1'b1;
            cmd.clr_word = 1'b1;
            fin = 1'b0;
            state_next = S_MEMW;
          end
          I_SWAP: begin
            cmd.write_b_swap = 1'b1;
            fin = 1'b0;
            state_next = S_MULW;
          end
          I_MOVEIF: cmd.write_a = !sts.vc_zero;
          I_MOVEIFZ: cmd.write_a = sts.vc_zero;
          I_STOP: set_stop = 1'b1;
          I_MUL: begin
            fin = 1'b0;
            state_next = S_MULW;
          end
          I_DIV: begin
            if (sts.vc_zero) begin
              fin_st = ST_FAULT;
            end else begin
              cmd.div_start = 1'b1;
              fin = 1'b0;
              state_next = S_DIVW;
            end
          end
          I_OUT: fin_ov = 1'b1;
          I_MOVE, I_LSH, I_RSH, I_SSH, I_AND, I_OR, I_XOR, I_NEG, I_INCR,
          I_DECR, I_INCR4, I_DECR4, I_ADD, I_SUB, I_IN: cmd.write_a = 1'b1;
          default: fin_st = ST_BADOP;
        endcase
      end
      S_MEMW: begin
        // base is now latched; check the range before any access.
        cnt_next = '0;
        if (!sts.addr_ok) begin
          fin = 1'b1;
          fin_st = ST_FAULT;
          state_next = S_IDLE;
        end else begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        cmd.addr_sel = 2'd2;
        cmd.k = cnt[1:0];
        cnt_next = cnt + 3'd1;
        if (is_wr) begin
          cmd.mem_wr = 1'b1;
          cmd.wr_sel = 2'd1;
          if (cnt + 3'd1 == nbytes) begin
            fin = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.mem_rd = cnt < nbytes;
          cmd.cap_word = cnt != 3'd0;
          if (cnt == nbytes) begin
            cmd.write_a = 1'b1;
            cmd.pc_adv = opc == I_LOAD;
            fin = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_MULW: begin
        // Product register settles in the cycle after the operands; swap ends here.
        cmd.write_a = 1'b1;
        fin = 1'b1;
        state_next = S_IDLE;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.write_rem = 1'b1;
          cmd.write_a = 1'b1;
          fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      done <= 1'b0;
      status <= ST_OK;
      out_valid <= 1'b0;
      call_valid <= 1'b0;
      stopped <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      done <= fin;
      status <= fin_st;
      out_valid <= fin_ov;
      call_valid <= fin_call;
      if (set_stop) stopped <= 1'b1;
      if (clr_stop) stopped <= 1'b0;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fin)) else $error("done without finish");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && call_valid)) else $error("out and call together");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_EXEC) |=> busy) else $error("exec not started");
endmodule
`default_nettype wire

[rtl/register_vm_instruction_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// register_vm_instruction_step
// 32-register virtual machine that runs one command per start beat.
// ----------------------------------------------------------------------------
// Usage: pulse start with op and the item fields while busy is low. Op 0
// writes load_byte to memory at load_addr, op 1 sets pc and clears the stop
// flag, op 2 runs one instruction. Every beat ends with one result beat on
// status, out_valid, out_char, call_index, pc and stopped, marked by done
// for one cycle; the receiver must take it then.
// Load and set items finish in the idle state and never raise busy. An
// instruction passes through fetch, operand read and dispatch, then for
// memory opcodes a range check and byte accesses one at a time through the
// single-port byte memory, and for divide the bit-serial divider. busy is
// high while an instruction is at work.
// Reset clears the registers, the stop flag and function_count; memory is
// not cleared. function_count is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module register_vm_instruction_step import rvm_pkg::*; #(
  parameter int MEM_BYTES = MemBytesDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [0:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        op,
  input  wire logic [15:0]       load_addr,
  input  wire logic [7:0]        load_byte,
  input  wire logic [31:0]       new_pc,
  input  wire logic signed [8:0] in_char,
  output logic                   done,
  output logic [2:0]             status,
  output logic                   out_valid,
  output logic [7:0]             out_char,
  output logic [31:0]            call_index,
  output logic [31:0]            pc,
  output logic                   stopped
);
  logic [7:0]  function_count;
  rvm_cmd_t    cmd;
  rvm_sts_t    sts;
  logic [7:0]  oc_val;
  logic [31:0] ci_val;
  logic        call_valid;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, function_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) function_count <= '0;
    else if (psel && penable && pwrite && paddr == 1'b0) function_count <= pwdata[7:0];
  end

  rvm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .sts(sts), .cmd(cmd),
    .busy(busy), .done(done), .status(status), .out_valid(out_valid),
    .call_valid(call_valid), .stopped(stopped)
  );

  rvm_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .load_addr(load_addr),
    .load_byte(load_byte), .new_pc(new_pc), .in_char(in_char),
    .function_count(function_count), .pc(pc), .out_char_val(oc_val),
    .call_val(ci_val)
  );

  assign out_char = out_valid ? oc_val : 8'd0;
  assign call_index = call_valid ? ci_val : 32'd0;
endmodule
`default_nettype wire

[sim/tb_register_vm_instruction_step.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_vm_instruction_step
// Self-checking bench for the register VM: writes each byte before a program
// reads it, runs directed and random programs under several sender idle
// rates and function_count values, and checks every result beat against a
// behavioral model of the machine.
// ----------------------------------------------------------------------------
module tb_register_vm_instruction_step;
  import rvm_pkg::*;

  localparam int MEM_SIZE = 65536;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1800;

  typedef struct {
    logic [1:0]        op;
    logic [15:0]       load_addr;
    logic [7:0]        load_byte;
    logic [31:0]       new_pc;
    logic signed [8:0] in_char;
  } vm_item_t;

  typedef struct {
    logic [2:0]  status;
    logic        out_valid;
    logic [7:0]  out_char;
    logic [31:0] call_index;
    logic [31:0] pc;
    logic        stopped;
  } vm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = '0;
  logic [15:0] load_addr = '0;
  logic [7:0] load_byte = '0;
  logic [31:0] new_pc = '0;
  logic signed [8:0] in_char = '0;
  logic done;
  logic [2:0] status;
  logic out_valid;
  logic [7:0] out_char;
  logic [31:0] call_index;
  logic [31:0] pc;
  logic stopped;

  // Machine state as the model sees it.
  logic [31:0] vm_reg [32];
  logic [7:0]  vm_mem [MEM_SIZE];
  bit          vm_written [MEM_SIZE];
  logic        vm_halted;
  logic [7:0]  fn_count;

  vm_item_t   pending_items[$];
  vm_result_t planned_results[$];
  vm_result_t expected_results[$];
  vm_item_t   cur_item;
  vm_result_t cur_result;
  int idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int items_made = 0;

  register_vm_instruction_step dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .op(op), .load_addr(load_addr),
    .load_byte(load_byte), .new_pc(new_pc), .in_char(in_char), .done(done),
    .status(status), .out_valid(out_valid), .out_char(out_char),
    .call_index(call_index), .pc(pc), .stopped(stopped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] mem_word(logic [31:0] a);
    return {vm_mem[a[15:0]], vm_mem[a[15:0] + 16'd1], vm_mem[a[15:0] + 16'd2],
            vm_mem[a[15:0] + 16'd3]};
  endfunction

  // Runs one instruction at pc and fills in the result fields.
  function automatic void run_instruction(logic [8:0] ch, inout vm_result_t r);
    logic [31:0] ipc, vb, vc, t;
    logic [7:0] cmd;
    logic [4:0] a, b, c;
    ipc = vm_reg[0];
    if (longint'(ipc) + 4 > MEM_SIZE) begin
      r.status = ST_FAULT;
      return;
    end
    cmd = vm_mem[ipc[15:0]];
    a = vm_mem[ipc[15:0] + 16'd1][4:0];
    b = vm_mem[ipc[15:0] + 16'd2][4:0];
    c = vm_mem[ipc[15:0] + 16'd3][4:0];
    vm_reg[0] = ipc + 32'd4;
    vb = vm_reg[b];
    vc = vm_reg[c];
    case (cmd)
      I_NOP: ;
      I_LOAD: begin
        t = vm_reg[0];
        if (longint'(t) + 4 > MEM_SIZE) r.status = ST_FAULT;
        else begin
          vm_reg[0] = t + 32'd4;
          vm_reg[a] = mem_word(t);
        end
      end
      I_EXT: begin
        if (vm_reg[a] >= {24'd0, fn_count}) r.status = ST_BADFN;
        else begin
          r.status = ST_CALL;
          r.call_index = vm_reg[a];
        end
      end
      I_W8: begin
        t = vm_reg[a];
        if (longint'(t) >= MEM_SIZE) r.status = ST_FAULT;
        else begin
          vm_mem[t[15:0]] = vb[7:0];
          vm_written[t[15:0]] = 1'b1;
        end
      end
      I_R8: begin
        if (longint'(vb) >= MEM_SIZE) r.status = ST_FAULT;
        else vm_reg[a] = {24'd0, vm_mem[vb[15:0]]};
      end
      I_W16: begin
        t = vm_reg[a];
        if (longint'(t) + 1 >= MEM_SIZE) r.status = ST_FAULT;
        else begin
          vm_mem[t[15:0]] = vb[15:8];
          vm_mem[t[15:0] + 16'd1] = vb[7:0];
          vm_written[t[15:0]] = 1'b1;
          vm_written[t[15:0] + 16'd1] = 1'b1;
        end
      end
      I_R16: begin
        if (longint'(vb) + 1 >= MEM_SIZE) r.status = ST_FAULT;
        else vm_reg[a] = {16'd0, vm_mem[vb[15:0]], vm_mem[vb[15:0] + 16'd1]};
      end
      I_W32: begin
        t = vm_reg[a];
        if (longint'(vb) + 4 > MEM_SIZE) r.status = ST_FAULT;
        else begin
          vm_mem[vb[15:0]] = t[31:24];
          vm_mem[vb[15:0] + 16'd1] = t[23:16];
          vm_mem[vb[15:0] + 16'd2] = t[15:8];
          vm_mem[vb[15:0] + 16'd3] = t[7:0];
          for (int i = 0; i < 4; i++) vm_written[vb[15:0] + 16'(i)] = 1'b1;
        end
      end
      I_R32: begin
        if (longint'(vb) + 4 > MEM_SIZE) r.status = ST_FAULT;
        else vm_reg[a] = mem_word(vb);
      end
      I_SWAP: begin
        t = vm_reg[a];
        vm_reg[a] = vm_reg[b];
        vm_reg[b] = t;
      end
      I_MOVE: vm_reg[a] = vb;
      I_MOVEIF: if (vc != 0) vm_reg[a] = vb;
      I_MOVEIFZ: if (vc == 0) vm_reg[a] = vb;
      I_STOP: vm_halted = 1'b1;
      I_LSH: vm_reg[a] = vb << vc[4:0];
      I_RSH: vm_reg[a] = vb >> vc[4:0];
      I_SSH: vm_reg[a] = $signed(vb) >>> vc[4:0];
      I_AND: vm_reg[a] = vb & vc;
      I_OR: vm_reg[a] = vb | vc;
      I_XOR: vm_reg[a] = vb ^ vc;
      I_NEG: vm_reg[a] = ~vb;
      I_INCR: vm_reg[a] = vm_reg[a] + 32'd1;
      I_DECR: vm_reg[a] = vm_reg[a] - 32'd1;
      I_INCR4: vm_reg[a] = vm_reg[a] + 32'd4;
      I_DECR4: vm_reg[a] = vm_reg[a] - 32'd4;
      I_ADD: vm_reg[a] = vb + vc;
      I_SUB: vm_reg[a] = vb - vc;
      I_MUL: vm_reg[a] = vb * vc;
      I_DIV: begin
        if (vc == 0) r.status = ST_FAULT;
        else begin
          vm_reg[a] = vb / vc;
          vm_reg[31] = vb % vc;
        end
      end
      I_OUT: begin
        r.out_valid = 1'b1;
        r.out_char = vm_reg[a][7:0];
      end
      I_IN: vm_reg[a] = {{23{ch[8]}}, ch};
      default: r.status = ST_BADOP;
    endcase
  endfunction

  function automatic vm_result_t vm_step(vm_item_t it);
    vm_result_t r;
    r = '{status: ST_OK, out_valid: 1'b0, out_char: 8'd0, call_index: 32'd0,
          pc: 32'd0, stopped: 1'b0};
    case (it.op)
      OP_LOAD: begin
        vm_mem[it.load_addr] = it.load_byte;
        vm_written[it.load_addr] = 1'b1;
      end
      OP_SETPC: begin
        vm_reg[0] = it.new_pc;
        vm_halted = 1'b0;
      end
      OP_EXEC: run_instruction(it.in_char, r);
      default: ;
    endcase
    r.pc = vm_reg[0];
    r.stopped = vm_halted;
    return r;
  endfunction

  // Items go through the model as they are queued, since the block takes
  // them in exactly this order; the result waits beside its item.
  function automatic void add_item(logic [1:0] o, logic [15:0] addr,
                                   logic [7:0] data, logic [31:0] npc);
    vm_item_t it;
    it.op = o;
    it.load_addr = addr;
    it.load_byte = data;
    it.new_pc = npc;
    it.in_char = $urandom_range(3) == 0 ? -9'sd1 : 9'($urandom);
    if (o == OP_EXEC) cover_reads();
    pending_items.push_back(it);
    planned_results.push_back(vm_step(it));
    items_made++;
  endfunction

  function automatic void cover_byte(logic [31:0] a);
    if (longint'(a) < MEM_SIZE && !vm_written[a[15:0]])
      add_item(OP_LOAD, a[15:0], 8'($urandom), $urandom);
  endfunction

  // Writes every byte that the next instruction will read and that holds
  // no value yet, so the block never reads a byte nobody wrote.
  function automatic void cover_reads();
    logic [31:0] ipc, vb, t;
    logic [7:0] cmd;
    logic [4:0] b;
    int n;
    ipc = vm_reg[0];
    if (longint'(ipc) + 4 > MEM_SIZE) return;
    for (int i = 0; i < 4; i++) cover_byte(ipc + 32'(i));
    cmd = vm_mem[ipc[15:0]];
    b = vm_mem[ipc[15:0] + 16'd2][4:0];
    vb = (b == 5'd0) ? ipc + 32'd4 : vm_reg[b];
    n = 0;
    t = vb;
    case (cmd)
      I_LOAD: begin
        t = ipc + 32'd4;
        n = 4;
      end
      I_R8: n = 1;
      I_R16: n = 2;
      I_R32: n = 4;
      default: ;
    endcase
    for (int i = 0; i < n; i++) cover_byte(t + 32'(i));
  endfunction

  function automatic void add_exec();
    add_item(OP_EXEC, 16'($urandom), 8'($urandom), $urandom);
  endfunction

  function automatic void add_setpc(logic [31:0] npc);
    add_item(OP_SETPC, 16'($urandom), 8'($urandom), npc);
  endfunction

  // Places a byte image at base, points pc at it and steps through it.
  function automatic void add_code(logic [7:0] code[$], int base, int steps);
    for (int i = 0; i < code.size(); i++)
      add_item(OP_LOAD, 16'(base + i), code[i], $urandom);
    add_setpc(32'(base));
    for (int i = 0; i < steps; i++) add_exec();
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom_range(0, 300);
      1: return MEM_SIZE - $urandom_range(1, 6);
      2: return $urandom_range(0, MEM_SIZE - 1);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_random_program();
    logic [7:0] code[$];
    logic [31:0] imm;
    logic [7:0] cmd;
    int n, base;
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) cmd = I_LOAD;
      else if ($urandom_range(19) == 0) cmd = 8'($urandom_range(31, 255));
      else cmd = 8'($urandom_range(0, 30));
      code.push_back(cmd);
      for (int j = 0; j < 3; j++) code.push_back(8'($urandom));
      if (cmd == I_LOAD) begin
        imm = pick_value();
        for (int j = 3; j >= 0; j--) code.push_back(imm[8*j +: 8]);
      end
    end
    if ($urandom_range(7) == 0) base = MEM_SIZE - code.size();
    else base = $urandom_range(0, 1024);
    add_code(code, base, n + $urandom_range(0, 2));
    // Noise: stray set-pc, unused op and fetches out of range.
    if ($urandom_range(5) == 0) begin
      add_item(2'd3, 16'($urandom), 8'($urandom), $urandom);
      add_setpc($urandom_range(1) ? $urandom : MEM_SIZE - $urandom_range(1, 4));
      add_exec();
    end
  endfunction

  // Driver: presents the next pending beat when the block can take one, holding off at random by idle_pct.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(cur_result);
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = pending_items.pop_front();
          cur_result = planned_results.pop_front();
          start <= 1'b1;
          op <= cur_item.op;
          load_addr <= cur_item.load_addr;
          load_byte <= cur_item.load_byte;
          new_pc <= cur_item.new_pc;
          in_char <= cur_item.in_char;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // Monitor: each result beat is matched with the oldest expected result.
  always @(posedge clk) begin
    vm_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(status), 32'd0);
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
        if (out_valid !== e.out_valid)
          report_mismatch("out_valid", 32'(out_valid), 32'(e.out_valid));
        if (out_char !== e.out_char)
          report_mismatch("out_char", 32'(out_char), 32'(e.out_char));
        if (call_index !== e.call_index)
          report_mismatch("call_index", call_index, e.call_index);
        if (pc !== e.pc) report_mismatch("pc", pc, e.pc);
        if (stopped !== e.stopped) report_mismatch("stopped", 32'(stopped), 32'(e.stopped));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_fn_count(logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {$urandom_range(1) ? 24'hFFFFFF : 24'd0, value};
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    fn_count = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [7:0] code[$];
    logic [7:0] settings[5];
    for (int i = 0; i < 32; i++) vm_reg[i] = '0;
    for (int i = 0; i < MEM_SIZE; i++) begin
      vm_mem[i] = '0;
      vm_written[i] = 1'b0;
    end
    vm_halted = 1'b0;
    fn_count = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: immediates, divide by zero, arithmetic shift, stop, console,
    // external call with no functions, unknown opcodes, fetch at the very end.
    code = '{I_LOAD, 8'd1, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h10,
             I_LOAD, 8'd2, 8'd0, 8'd0, 8'h80, 8'h00, 8'h00, 8'h01,
             I_DIV, 8'd5, 8'd2, 8'd3, I_SSH, 8'd6, 8'd2, 8'd1,
             I_STOP, 8'd0, 8'd0, 8'd0, I_OUT, 8'hE2, 8'd0, 8'd0,
             I_IN, 8'd7, 8'd0, 8'd0, I_EXT, 8'd1, 8'd0, 8'd0,
             8'd31, 8'd0, 8'd0, 8'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF};
    add_code(code, 0, 10);
    add_item(2'd3, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    add_setpc(MEM_SIZE - 3);
    add_exec();
    add_setpc(32'hFFFF_FFFF);
    add_exec();
    code = '{I_NOP, 8'd0, 8'd0, 8'd0};
    add_code(code, MEM_SIZE - 4, 2);
    wait_idle();

    settings = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd0, 8'd128};
    for (int ph = 0; ph < 5; ph++) begin
      write_fn_count(settings[ph]);
      case (ph)
        1: idle_pct = 61;
        3: idle_pct = 13;
        default: idle_pct = 0;
      endcase
      while (items_made < (ph + 1) * ITEM_TARGET / 5) add_random_program();
      // The sender holds off here until every result is back.
      wait_idle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rvm_pkg.sv
rtl/rvm_div.sv
rtl/rvm_datapath.sv
rtl/rvm_ctrl.sv
rtl/register_vm_instruction_step.sv
sim/tb_register_vm_instruction_step.sv
